// ===== rtl/ymodem_receiver_defines.svh =====
// Assertion macros for the YMODEM receiver.
`ifndef YMODEM_RECEIVER_DEFINES_SVH
`define YMODEM_RECEIVER_DEFINES_SVH
// Concurrent check with synchronous reset disable.
`define YMR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Concurrent check that also holds during reset.
`define YMR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/ymr_pkg.sv =====
// Package: constants, types and helpers for the YMODEM receiver.
package ymr_pkg;

  localparam int ADDR_BITS_DEF   = 24;
  localparam int SIZE_DIGITS_DEF = 16;

  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_STX = 8'h02;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_CRC = 8'h43;
  localparam logic [7:0] BYTE_MASK = 8'hff;

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_BYTE    = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  localparam logic [1:0] KIND_SEND   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_COMMIT = 2'd2;
  localparam logic [1:0] KIND_FINISH = 2'd3;

  localparam logic [2:0] ST_COMPLETE = 3'd0;
  localparam logic [2:0] ST_CANCEL   = 3'd1;
  localparam logic [2:0] ST_TOO_BIG  = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_ERRORS   = 3'd4;

  localparam logic [0:0] REG_BUFFER_LENGTH = 1'd0;
  localparam logic [0:0] REG_ERROR_LIMIT   = 1'd1;

  typedef enum logic [2:0] {
    PH_WAIT = 3'b001,
    PH_CAN  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [24:0] addr;
    logic [2:0]  status;
    logic [31:0] done_size;
  } result_t;

  // Up to three results of one event.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
    result_t    r2;
  } result_set_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/ymr_core.sv =====
// Protocol state and per-event result generation.
module ymr_core #(
  parameter int ADDR_BITS   = ymr_pkg::ADDR_BITS_DEF,
  parameter int SIZE_DIGITS = ymr_pkg::SIZE_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                ev_valid,
  input  logic [1:0]          ev_cmd,
  input  logic [7:0]          ev_byte,
  input  logic [24:0]         buffer_length,
  input  logic [7:0]          error_limit,
  output ymr_pkg::result_set_t res
);
  import ymr_pkg::*;

  localparam logic [32:0] CAP_LIM = 33'd1 << ADDR_BITS;

  logic        active, fresh, long_packet, header_nonzero, want_crc_mode;
  phase_t      rx_phase;
  logic [10:0] byte_index;
  logic [7:0]  seq_byte, error_count;
  logic [1:0]  seq_flags;
  logic [15:0] crc_reg;
  logic [31:0] packets_received, accepted_size, pending_size;
  logic [24:0] write_offset;
  logic [1:0]  header_phase;
  logic [4:0]  digit_count;

  logic        active_next, fresh_next, long_packet_next, header_nonzero_next;
  logic        want_crc_mode_next;
  phase_t      rx_phase_next;
  logic [10:0] byte_index_next;
  logic [7:0]  seq_byte_next, error_count_next;
  logic [1:0]  seq_flags_next;
  logic [15:0] crc_reg_next;
  logic [31:0] packets_received_next, accepted_size_next, pending_size_next;
  logic [24:0] write_offset_next;
  logic [1:0]  header_phase_next;
  logic [4:0]  digit_count_next;

  logic [32:0] capacity;
  logic [10:0] ps;
  logic [10:0] p;
  logic [32:0] wr_addr;
  logic [32:0] end_off;
  logic [15:0] crc_new;
  logic        pkts_zero;
  logic [7:0]  err_inc;
  logic        idle_ev;

  assign capacity = ({8'd0, buffer_length} < CAP_LIM) ? {8'd0, buffer_length} : CAP_LIM;
  assign ps       = long_packet ? 11'd1024 : 11'd128;
  assign p        = byte_index - 11'd3;
  assign wr_addr  = {8'd0, write_offset} + {22'd0, p};
  assign end_off  = {8'd0, write_offset} + {22'd0, ps};
  assign crc_new  = crc_byte(crc_reg, ev_byte);
  assign pkts_zero = (packets_received == 32'd0);
  assign err_inc  = (error_count == 8'hff) ? error_count : error_count + 8'd1;
  assign idle_ev  = ev_valid && !active && ev_cmd != CMD_START;

  function automatic result_t mk(input logic [1:0] k, input logic [7:0] v,
                                 input logic [24:0] a, input logic [2:0] s,
                                 input logic [31:0] f);
    result_t r;
    r.kind = k; r.value = v; r.addr = a; r.status = s; r.done_size = f;
    return r;
  endfunction

  always_comb begin
    result_t q [3];
    logic [1:0] n;
    logic [10:0] bi;
    logic [1:0] sf;
    active_next = active; fresh_next = fresh; long_packet_next = long_packet;
    header_nonzero_next = header_nonzero; want_crc_mode_next = want_crc_mode;
    rx_phase_next = rx_phase; byte_index_next = byte_index; seq_byte_next = seq_byte;
    error_count_next = error_count; seq_flags_next = seq_flags; crc_reg_next = crc_reg;
    packets_received_next = packets_received; accepted_size_next = accepted_size;
    pending_size_next = pending_size; write_offset_next = write_offset;
    header_phase_next = header_phase; digit_count_next = digit_count;
    q[0] = '0; q[1] = '0; q[2] = '0; n = 2'd0; bi = '0; sf = seq_flags;

    if (ev_valid) begin
      if (ev_cmd == CMD_START) begin
        active_next = 1'b1; fresh_next = 1'b0; error_count_next = '0;
        accepted_size_next = '0; want_crc_mode_next = 1'b1;
        packets_received_next = '0; write_offset_next = '0; rx_phase_next = PH_WAIT;
      end else if (active && (ev_cmd == CMD_TIMEOUT || ev_cmd == CMD_BYTE)) begin
        if (rx_phase == PH_CAN) begin
          q[0] = mk(KIND_SEND, B_ACK, '0, '0, '0);
          q[1] = mk(KIND_FINISH, '0, '0, ST_CANCEL, '0);
          n = 2'd2; active_next = 1'b0; rx_phase_next = PH_WAIT;
        end else if (ev_cmd == CMD_TIMEOUT) begin
          rx_phase_next = PH_WAIT;
          if (!pkts_zero && err_inc >= error_limit) begin
            error_count_next = err_inc;
            q[0] = mk(KIND_SEND, B_CAN, '0, '0, '0);
            q[1] = mk(KIND_SEND, B_CAN, '0, '0, '0);
            q[2] = mk(KIND_FINISH, '0, '0, ST_ERRORS, '0);
            n = 2'd3; active_next = 1'b0;
          end else begin
            if (!pkts_zero) error_count_next = err_inc;
            q[0] = mk(KIND_SEND, B_CRC, '0, '0, '0); n = 2'd1;
          end
        end else if (rx_phase == PH_BODY) begin
          if (byte_index == 11'd1) begin
            seq_byte_next = ev_byte;
            if (ev_byte == packets_received[7:0]) sf[1] = 1'b1;
          end else if (byte_index == 11'd2) begin
            if (seq_byte == (ev_byte ^ BYTE_MASK)) sf[0] = 1'b1;
          end else begin
            crc_reg_next = crc_new;
            if (byte_index < ps + 11'd3) begin
              if (p < 11'd4 && ev_byte != 8'd0) header_nonzero_next = 1'b1;
              if (header_phase == 2'd0) begin
                if (ev_byte == 8'd0) header_phase_next = 2'd1;
              end else if (header_phase == 2'd1) begin
                if (ev_byte == 8'h20 || digit_count >= 5'(SIZE_DIGITS)) begin
                  header_phase_next = 2'd2;
                end else begin
                  digit_count_next = digit_count + 5'd1;
                  if (ev_byte >= 8'h30 && ev_byte <= 8'h39)
                    pending_size_next = pending_size * 32'd10 + {28'd0, ev_byte[3:0]};
                  else
                    header_phase_next = 2'd2;
                end
              end
              if (!pkts_zero && seq_flags == 2'b11 && wr_addr < capacity) begin
                q[0] = mk(KIND_WRITE, ev_byte, wr_addr[24:0], '0, '0); n = 2'd1;
              end
            end
          end
          seq_flags_next = sf;
          bi = byte_index + 11'd1;
          byte_index_next = bi;
          if (bi >= ps + 11'd5) begin
            rx_phase_next = PH_WAIT;
            if (!sf[0] || crc_new != 16'd0) begin
              if (!pkts_zero && err_inc >= error_limit) begin
                error_count_next = err_inc;
                q[0] = mk(KIND_SEND, B_CAN, '0, '0, '0);
                q[1] = mk(KIND_SEND, B_CAN, '0, '0, '0);
                q[2] = mk(KIND_FINISH, '0, '0, ST_ERRORS, '0);
                n = 2'd3; active_next = 1'b0;
              end else begin
                if (!pkts_zero) error_count_next = err_inc;
                q[0] = mk(KIND_SEND, B_CRC, '0, '0, '0); n = 2'd1;
              end
            end else begin
              error_count_next = '0;
              if (!sf[1]) begin
                q[0] = mk(KIND_SEND, B_NAK, '0, '0, '0); n = 2'd1;
              end else if (pkts_zero) begin
                if (!header_nonzero) begin
                  q[0] = mk(KIND_SEND, B_ACK, '0, '0, '0);
                  q[1] = mk(KIND_FINISH, '0, '0, ST_COMPLETE, accepted_size);
                  n = 2'd2; active_next = 1'b0;
                end else begin
                  accepted_size_next = pending_size;
                  if ({1'b0, pending_size} > capacity) begin
                    q[0] = mk(KIND_SEND, B_CAN, '0, '0, '0);
                    q[1] = mk(KIND_SEND, B_CAN, '0, '0, '0);
                    q[2] = mk(KIND_FINISH, '0, '0, ST_TOO_BIG, '0);
                    n = 2'd3; active_next = 1'b0;
                  end else begin
                    q[0] = mk(KIND_SEND, B_ACK, '0, '0, '0);
                    q[1] = mk(KIND_SEND, want_crc_mode ? B_CRC : B_NAK, '0, '0, '0);
                    n = 2'd2; want_crc_mode_next = 1'b0;
                    packets_received_next = packets_received + 32'd1;
                  end
                end
              end else if (end_off > capacity) begin
                q[0] = mk(KIND_SEND, B_CAN, '0, '0, '0);
                q[1] = mk(KIND_SEND, B_CAN, '0, '0, '0);
                q[2] = mk(KIND_FINISH, '0, '0, ST_OVERFLOW, '0);
                n = 2'd3; active_next = 1'b0;
              end else begin
                write_offset_next = end_off[24:0];
                q[0] = mk(KIND_COMMIT, '0, end_off[24:0], '0, '0);
                q[1] = mk(KIND_SEND, B_ACK, '0, '0, '0);
                n = 2'd2; packets_received_next = packets_received + 32'd1;
              end
            end
          end
        end else if (ev_byte == B_SOH || ev_byte == B_STX) begin
          long_packet_next = (ev_byte == B_STX); rx_phase_next = PH_BODY;
          byte_index_next = 11'd1; seq_byte_next = '0; seq_flags_next = '0;
          crc_reg_next = '0; header_phase_next = '0; digit_count_next = '0;
          header_nonzero_next = 1'b0; pending_size_next = '0;
        end else if (ev_byte == B_EOT) begin
          error_count_next = '0;
          q[0] = mk(KIND_SEND, B_ACK, '0, '0, '0); n = 2'd1;
          want_crc_mode_next = 1'b1; packets_received_next = '0;
          write_offset_next = '0; rx_phase_next = PH_WAIT;
          if (!fresh) begin
            q[1] = mk(KIND_SEND, B_CRC, '0, '0, '0); n = 2'd2;
          end
          fresh_next = 1'b0;
        end else if (ev_byte == B_CAN) begin
          rx_phase_next = PH_CAN;
        end else begin
          q[0] = mk(KIND_SEND, B_ACK, '0, '0, '0);
          q[1] = mk(KIND_FINISH, '0, '0, ST_CANCEL, '0);
          n = 2'd2; active_next = 1'b0; rx_phase_next = PH_WAIT;
        end
      end
    end
    res.count = n; res.r0 = q[0]; res.r1 = q[1]; res.r2 = q[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0; fresh <= 1'b1; rx_phase <= PH_WAIT; byte_index <= '0;
      long_packet <= 1'b0; seq_byte <= '0; seq_flags <= '0; crc_reg <= '0;
      packets_received <= '0; error_count <= '0; want_crc_mode <= 1'b1;
      write_offset <= '0; accepted_size <= '0; pending_size <= '0;
      header_phase <= '0; digit_count <= '0; header_nonzero <= 1'b0;
    end else begin
      active <= active_next; fresh <= fresh_next; rx_phase <= rx_phase_next;
      byte_index <= byte_index_next; long_packet <= long_packet_next;
      seq_byte <= seq_byte_next; seq_flags <= seq_flags_next; crc_reg <= crc_reg_next;
      packets_received <= packets_received_next; error_count <= error_count_next;
      want_crc_mode <= want_crc_mode_next; write_offset <= write_offset_next;
      accepted_size <= accepted_size_next; pending_size <= pending_size_next;
      header_phase <= header_phase_next; digit_count <= digit_count_next;
      header_nonzero <= header_nonzero_next;
    end
  end

`include "ymodem_receiver_defines.svh"
  `YMR_ASSERT(a_phase_onehot, $onehot(rx_phase), "rx phase not one-hot")
  `YMR_ASSERT(a_body_index, (rx_phase == PH_BODY) |-> (byte_index != 11'd0), "body index zero")
  `YMR_ASSERT(a_inactive_quiet, idle_ev |-> (res.count == 2'd0), "result while idle")
endmodule

// ===== rtl/ymr_out_queue.sv =====
// Output queue: holds up to three results per event and streams them out.
module ymr_out_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  ymr_pkg::result_set_t set_in,
  output logic                 can_load,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [71:0]          m_axis_tdata,
  output logic                 m_axis_tlast
);
  import ymr_pkg::*;

  result_t    slot [3];
  logic [1:0] cnt;
  logic [1:0] rd;
  logic       pop;
  result_t    cur;

  assign cur = slot[rd];
  assign m_axis_tvalid = (cnt != 2'd0);
  assign pop = m_axis_tvalid && m_axis_tready;
  assign can_load = (cnt == 2'd0) || (pop && cnt == 2'd1);
  assign m_axis_tlast = (cnt == 2'd1);
  assign m_axis_tdata = {2'b00, cur.done_size, cur.status, cur.addr, cur.value, cur.kind};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; rd <= '0;
    end else if (load && set_in.count != 2'd0) begin
      cnt <= set_in.count; rd <= '0;
    end else if (pop) begin
      cnt <= cnt - 2'd1; rd <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot[0] <= set_in.r0; slot[1] <= set_in.r1; slot[2] <= set_in.r2;
    end
  end

`include "ymodem_receiver_defines.svh"
  `YMR_ASSERT(a_cnt_range, cnt != 2'd3 || rd == 2'd0, "queue read pointer skew")
  `YMR_ASSERT(a_rd_range, m_axis_tvalid |-> (rd != 2'd3), "read index out of range")
  `YMR_ASSERT(a_no_overwrite, (load && set_in.count != 2'd0) |-> can_load, "load over pending")
endmodule

// ===== rtl/ymodem_receiver.sv =====
// YMODEM receiver top level: config registers, input register, core, output queue.
// Flow: an event beat is registered at acceptance; its results load the output queue
//   once the queue can take them, and are then streamed out one result per beat.
// Throughput: one event beat per cycle unless the queue is busy; k results hold it for k beats.
// Reset: synchronous active-high rst clears session state and restores registers
//   to buffer_length 16777216 and error_limit 5.
module ymodem_receiver #(
  parameter int ADDR_BITS   = ymr_pkg::ADDR_BITS_DEF,
  parameter int SIZE_DIGITS = ymr_pkg::SIZE_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [24:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // cmd[1:0], rx_byte[9:2], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // kind, value, addr, status, done_size, zero fill
  output logic        m_axis_tlast
);
  import ymr_pkg::*;

  logic [24:0] buffer_length;
  logic [7:0]  error_limit;
  logic        in_valid;
  logic [1:0]  in_cmd;
  logic [7:0]  in_byte;
  logic        can_load;
  logic        step;
  result_set_t res;

  // Input register advances when the core can hand its results to the queue.
  assign step = !in_valid || can_load;
  assign s_axis_tready = step;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length <= 25'd16777216;
      error_limit   <= 8'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BUFFER_LENGTH: buffer_length <= cfg_data;
        REG_ERROR_LIMIT:   error_limit   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (step) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      in_cmd  <= s_axis_tdata[1:0];
      in_byte <= s_axis_tdata[9:2];
    end
  end

  ymr_core #(.ADDR_BITS(ADDR_BITS), .SIZE_DIGITS(SIZE_DIGITS)) u_core (
    .clk, .rst,
    .ev_valid(in_valid && can_load),
    .ev_cmd(in_cmd), .ev_byte(in_byte),
    .buffer_length, .error_limit, .res
  );

  ymr_out_queue u_queue (
    .clk, .rst,
    .load(in_valid && can_load), .set_in(res), .can_load,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

`include "ymodem_receiver_defines.svh"
  `YMR_ASSERT(a_hold_blocked, (in_valid && !can_load) |-> !s_axis_tready, "blocked accept")
  `YMR_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !m_axis_tvalid, "output valid after reset")
  `YMR_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "result dropped")
endmodule

// ===== test/ymodem_receiver_check.sv =====
// Checker for the YMODEM receiver: predicts the reply stream and compares it.
module ymodem_receiver_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [24:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          failures,
  output int          waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import ymr_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [24:0] addr;
    logic [2:0]  status;
    logic [31:0] fsize;
    logic        last;
  } reply_t;

  reply_t replies_due[$];
  reply_t step_replies[$];

  logic [24:0] buf_len;
  logic [7:0]  err_lim;
  logic        active, fresh, long_pkt, hdr_nz, want_c, num_ok, cmp_ok;
  phase_t      phase;
  logic [10:0] idx;
  logic [7:0]  seq_b, errs;
  logic [15:0] crc;
  logic [31:0] pkts, acc_size, pend_size;
  logic [24:0] woff;
  logic [1:0]  hdr_phase;
  logic [4:0]  digits;

  function automatic logic [63:0] capacity();
    return (buf_len < 25'd16777216) ? 64'(buf_len) : 64'd16777216;
  endfunction

  function automatic void emit(logic [1:0] kind, logic [7:0] value, logic [24:0] addr,
                               logic [2:0] status, logic [31:0] fsize);
    reply_t r;
    r.kind = kind; r.value = value; r.addr = addr;
    r.status = status; r.fsize = fsize; r.last = 1'b0;
    step_replies.push_back(r);
  endfunction

  function automatic void send_byte(logic [7:0] b);
    emit(KIND_SEND, b, '0, '0, '0);
  endfunction

  function automatic void finish_session(logic [2:0] st);
    emit(KIND_FINISH, '0, '0, st, (st == ST_COMPLETE) ? acc_size : 32'd0);
    active = 1'b0;
    phase = PH_WAIT;
  endfunction

  function automatic void cancel_with(logic [2:0] st);
    send_byte(B_CAN);
    send_byte(B_CAN);
    finish_session(st);
  endfunction

  // bad packet or timeout: only counts once the header got through
  function automatic void error_path();
    phase = PH_WAIT;
    if (pkts != 0) begin
      if (errs != 8'd255) errs++;
      if (errs >= err_lim) begin
        cancel_with(ST_ERRORS);
        return;
      end
    end
    send_byte(B_CRC);
  endfunction

  function automatic void begin_file();
    want_c = 1'b1;
    pkts = '0;
    woff = '0;
    phase = PH_WAIT;
  endfunction

  function automatic void crc_update(logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    crc = c;
  endfunction

  // header: name up to NUL, then decimal size up to a space, a non-digit or the digit limit
  function automatic void header_byte(int p, logic [7:0] b);
    if (p < 4 && b != 0) hdr_nz = 1'b1;
    if (hdr_phase == 0) begin
      if (b == 0) hdr_phase = 1;
    end else if (hdr_phase == 1) begin
      if (b == 8'h20 || digits >= SIZE_DIGITS_DEF) begin
        hdr_phase = 2;
      end else begin
        digits++;
        if (b >= "0" && b <= "9") pend_size = pend_size * 10 + 32'(b - "0");
        else hdr_phase = 2;
      end
    end
  endfunction

  function automatic void end_packet(int ps);
    phase = PH_WAIT;
    if (!cmp_ok || crc != 0) begin
      error_path();
      return;
    end
    errs = '0;
    if (!num_ok) begin
      send_byte(B_NAK);
      return;
    end
    if (pkts == 0) begin
      if (!hdr_nz) begin
        send_byte(B_ACK);
        finish_session(ST_COMPLETE);
        return;
      end
      acc_size = pend_size;
      if (64'(acc_size) > capacity()) begin
        cancel_with(ST_TOO_BIG);
        return;
      end
      send_byte(B_ACK);
      send_byte(want_c ? B_CRC : B_NAK);
      want_c = 1'b0;
    end else begin
      if (64'(woff) + 64'(ps) > capacity()) begin
        cancel_with(ST_OVERFLOW);
        return;
      end
      woff = woff + 25'(ps);
      emit(KIND_COMMIT, '0, woff, '0, '0);
      send_byte(B_ACK);
    end
    pkts++;
  endfunction

  function automatic void body_byte(logic [7:0] b);
    int ps;
    int i;
    logic [63:0] a;
    ps = long_pkt ? 1024 : 128;
    i = idx;
    if (i == 1) begin
      seq_b = b;
      if (b == pkts[7:0]) num_ok = 1'b1;
    end else if (i == 2) begin
      if (seq_b == (b ^ BYTE_MASK)) cmp_ok = 1'b1;
    end else begin
      crc_update(b);
      if (i < 3 + ps) begin
        header_byte(i - 3, b);
        if (pkts != 0 && num_ok && cmp_ok) begin
          a = 64'(woff) + 64'(i - 3);
          if (a < capacity()) emit(KIND_WRITE, b, a[24:0], '0, '0);
        end
      end
    end
    idx = idx + 11'd1;
    if (idx >= ps + 5) end_packet(ps);
  endfunction

  function automatic void start_packet(logic lng);
    long_pkt = lng;
    phase = PH_BODY;
    idx = 11'd1;
    seq_b = '0;
    num_ok = 1'b0;
    cmp_ok = 1'b0;
    crc = '0;
    hdr_phase = '0;
    digits = '0;
    hdr_nz = 1'b0;
    pend_size = '0;
  endfunction

  function automatic void predict_event(logic [1:0] cmd, logic [7:0] b);
    step_replies.delete();
    if (cmd == CMD_START) begin
      active = 1'b1;
      fresh = 1'b0;
      errs = '0;
      acc_size = '0;
      begin_file();
      return;
    end
    if (!active || !(cmd == CMD_BYTE || cmd == CMD_TIMEOUT)) return;
    if (cmd == CMD_TIMEOUT) begin
      if (phase == PH_CAN) begin
        send_byte(B_ACK);
        finish_session(ST_CANCEL);
      end else begin
        error_path();
      end
    end else if (phase == PH_CAN) begin
      send_byte(B_ACK);
      finish_session(ST_CANCEL);
    end else if (phase == PH_BODY) begin
      body_byte(b);
    end else if (b == B_SOH) begin
      start_packet(1'b0);
    end else if (b == B_STX) begin
      start_packet(1'b1);
    end else if (b == B_EOT) begin
      errs = '0;
      send_byte(B_ACK);
      begin_file();
      if (!fresh) send_byte(B_CRC);
      fresh = 1'b0;
    end else if (b == B_CAN) begin
      phase = PH_CAN;
    end else begin
      send_byte(B_ACK);
      finish_session(ST_CANCEL);
    end
    if (step_replies.size() > 0) step_replies[step_replies.size() - 1].last = 1'b1;
    foreach (step_replies[k]) replies_due.push_back(step_replies[k]);
  endfunction

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst) begin
      buf_len = 25'd16777216;
      err_lim = 8'd5;
      active = 1'b0;
      fresh = 1'b1;
      phase = PH_WAIT;
      idx = '0;
      long_pkt = 1'b0;
      seq_b = '0;
      num_ok = 1'b0;
      cmp_ok = 1'b0;
      crc = '0;
      pkts = '0;
      errs = '0;
      want_c = 1'b1;
      woff = '0;
      acc_size = '0;
      pend_size = '0;
      hdr_phase = '0;
      digits = '0;
      hdr_nz = 1'b0;
      replies_due.delete();
      failures = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BUFFER_LENGTH) buf_len = cfg_data;
        else err_lim = cfg_data[7:0];
      end
      if (s_axis_tvalid && s_axis_tready) predict_event(s_axis_tdata[1:0], s_axis_tdata[9:2]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tdata[1:0];
        got.value = m_axis_tdata[9:2];
        got.addr = m_axis_tdata[34:10];
        got.status = m_axis_tdata[37:35];
        got.fsize = m_axis_tdata[69:38];
        got.last = m_axis_tlast;
        if (replies_due.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected reply beat: kind %0d value %h addr %0d status %0d size %0d",
                     got.kind, got.value, got.addr, got.status, got.fsize);
        end else begin
          want = replies_due.pop_front();
          if (got != want) begin
            failures++;
            if (failures <= 10)
              $display({"reply mismatch: want kind %0d value %h addr %0d status %0d size %0d",
                        " last %0d, got kind %0d value %h addr %0d status %0d size %0d last %0d"},
                       want.kind, want.value, want.addr, want.status, want.fsize, want.last,
                       got.kind, got.value, got.addr, got.status, got.fsize, got.last);
          end
        end
      end
    end
    waiting = replies_due.size();
  end

endmodule

// ===== test/ymodem_receiver_test.sv =====
// Testbench top for the YMODEM receiver: packet stimulus, back-pressure and verdict.
module ymodem_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ymr_pkg::*;

  // cmd code the block ignores
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int ITEMS = 310;

  typedef enum {FLAW_NONE, FLAW_CRC, FLAW_COMPL, FLAW_CUT} flaw_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [24:0] cfg_data;
  logic        s_valid;
  logic        s_ready;
  logic [15:0] s_data;
  logic        m_valid;
  logic        m_ready;
  logic [71:0] m_data;
  logic        m_last;
  int          failures;
  int          waiting;

  int          burst_left;
  int          beats;
  int          stall_cyc;
  logic [7:0]  body [0:1023];   // payload of the packet being built

  ymodem_receiver uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
    .s_axis_tdata(s_data),     // cmd, rx_byte, zero fill
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data),     // kind, value, addr, status, done_size, zero fill
    .m_axis_tlast(m_last)
  );

  ymodem_receiver_check chk (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
    .m_axis_tlast(m_last),
    .failures(failures), .waiting(waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls: free-running, coin flip, then one-in-four, in turn
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1;
    case ((stall_cyc / 300) % 3)
      0: begin
        m_ready <= 1'b1;
      end
      1: begin
        m_ready <= $urandom_range(0, 1);
      end
      default: begin
        m_ready <= (stall_cyc % 4 == 0);
      end
    endcase
  end

  // sender works in bursts; one beat per call, returns at the accepting edge
  task automatic beat(input logic [1:0] cmd, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data <= {6'd0, b, cmd};
    do @(posedge clk); while (!s_ready);
    beats++;
  endtask

  // drain: all replies in, then slack for a beat that gave nothing yet
  task automatic settle();
    int n;
    s_valid <= 1'b0;
    burst_left = 0;
    n = 0;
    repeat (4) @(posedge clk);
    while (waiting != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] index, input logic [24:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
    return r;
  endfunction

  function automatic void fill_random();
    for (int i = 0; i < 1024; i++) body[i] = 8'($urandom);
  endfunction

  function automatic void fill_null();
    for (int i = 0; i < 1024; i++) body[i] = 8'h00;
  endfunction

  // style 0: name NUL size space; 1: twenty digits; 2: size then a letter; 3: garbage
  function automatic void fill_header(input logic [31:0] size, input int style);
    int p;
    int nd;
    logic [7:0] dig [0:9];
    logic [31:0] v;
    fill_null();
    if (style == 3) begin
      fill_random();
      return;
    end
    p = $urandom_range(1, 8);
    for (int i = 0; i < p; i++) body[i] = 8'($urandom_range("a", "z"));
    p++;
    if (style == 1) begin
      for (int i = 0; i < 20; i++) body[p + i] = 8'("0" + $urandom_range(0, 9));
      body[p + 20] = 8'h20;
      return;
    end
    v = size;
    nd = 0;
    do begin
      dig[nd] = "0" + 8'(v % 10);
      nd++;
      v = v / 10;
    end while (v != 0);
    for (int k = nd - 1; k >= 0; k--) begin
      body[p] = dig[k];
      p++;
    end
    if (style == 2) begin
      body[p] = "k";
      p++;
    end
    body[p] = 8'h20;
  endfunction

  // one framed packet from body[], optionally damaged or cut off early by a timeout
  task automatic packet(input bit lng, input logic [7:0] seq, input flaw_t flaw);
    int n;
    int cut;
    logic [15:0] c;
    logic [7:0] b;
    n = lng ? 1024 : 128;
    c = '0;
    for (int i = 0; i < n; i++) c = crc_next(c, body[i]);
    if (flaw == FLAW_CRC) c = c ^ (16'h0001 << $urandom_range(0, 15));
    cut = (flaw == FLAW_CUT) ? $urandom_range(0, 12) : n + 4;
    beat(CMD_BYTE, lng ? B_STX : B_SOH);
    for (int k = 0; k < n + 4; k++) begin
      if (k == cut) begin
        beat(CMD_TIMEOUT, 8'($urandom));
        return;
      end
      if (k == 0) b = seq;
      else if (k == 1) b = (flaw == FLAW_COMPL) ? ~seq ^ (8'h01 << $urandom_range(0, 7)) : ~seq;
      else if (k < n + 2) b = body[k - 2];
      else if (k == n + 2) b = c[15:8];
      else b = c[7:0];
      beat(CMD_BYTE, b);
    end
  endtask

  initial begin
    int r;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_valid = 1'b0;
    s_data = '0;
    m_ready = 1'b0;
    stall_cyc = 0;
    burst_left = 0;
    beats = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, default registers: events with no session, then header and data
    beat(CMD_BYTE, B_SOH);
    beat(CMD_TIMEOUT, 8'h00);
    beat(CMD_NOP, 8'hff);
    beat(CMD_START, 8'h00);
    beat(CMD_NOP, 8'h00);
    fill_header(32'd300, 0);
    packet(1'b0, 8'h00, FLAW_CUT);    // cut before any accepted: no error
    packet(1'b0, 8'h00, FLAW_NONE);
    fill_random();
    packet(1'b0, 8'h01, FLAW_CUT);    // counted error, then resend
    packet(1'b0, 8'h01, FLAW_NONE);
    beat(CMD_TIMEOUT, 8'h00);
    beat(CMD_BYTE, B_EOT);
    beat(CMD_BYTE, B_CAN);
    beat(CMD_BYTE, 8'hff);
    beat(CMD_START, 8'h00);
    beat(CMD_BYTE, B_CAN);
    beat(CMD_TIMEOUT, 8'h00);
    beat(CMD_START, 8'h00);
    beat(CMD_BYTE, 8'hff);
    settle();

    // small buffer, tight error budget, then random events up to the item count
    write_reg(REG_BUFFER_LENGTH, 25'($urandom_range(0, 3000)));
    write_reg(REG_ERROR_LIMIT, 8'($urandom_range(1, 8)));
    while (beats < ITEMS) begin
      r = $urandom_range(0, 15);
      if (r == 0) beat(CMD_START, 8'h00);
      else if (r == 1) beat(CMD_TIMEOUT, 8'h00);
      else if (r == 2) beat(CMD_NOP, 8'($urandom));
      else if (r < 6) beat(CMD_BYTE, r == 3 ? B_SOH : r == 4 ? B_EOT : B_CAN);
      else beat(CMD_BYTE, 8'($urandom));
    end
    settle();

    if (failures == 0 && waiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ymr_pkg.sv
rtl/ymr_core.sv
rtl/ymr_out_queue.sv
rtl/ymodem_receiver.sv
test/ymodem_receiver_check.sv
test/ymodem_receiver_test.sv
